[rtl/core/ccs_pkg.sv]
// Shared types and outcome codes for the circle collision separation pipeline.
package ccs_pkg;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_step_ctl;

    localparam logic [1:0] OUTCOME_APART    = 2'd0;
    localparam logic [1:0] OUTCOME_GHOST    = 2'd1;
    localparam logic [1:0] OUTCOME_RESOLVED = 2'd2;

endpackage

[rtl/core/ccs_sqrt_cell.sv]
// One root bit of the integer square root chain, with a sidecar register.
module ccs_sqrt_cell import ccs_pkg::*; #(
    parameter int RTW = 25,
    parameter int SW  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step_ctl          i_ctl,
    input  logic [RTW+1:0]     i_rem,
    input  logic [RTW-1:0]     i_root,
    input  logic [2*RTW-1:0]   i_src,
    input  logic [SW-1:0]      i_side,
    output logic               o_vld,
    output logic [RTW+1:0]     o_rem,
    output logic [RTW-1:0]     o_root,
    output logic [2*RTW-1:0]   o_src,
    output logic [SW-1:0]      o_side
);

    logic [RTW+3:0]   w_t;
    logic [RTW+3:0]   w_trial;
    logic [RTW+3:0]   w_diff;
    logic             w_ge;
    logic             r_vld;
    logic [RTW+1:0]   r_rem;
    logic [RTW-1:0]   r_root;
    logic [2*RTW-1:0] r_src;
    logic [SW-1:0]    r_side;
    logic [RTW+1:0]   n_rem;
    logic [RTW-1:0]   n_root;
    logic [2*RTW-1:0] n_src;

    always_comb begin
        w_t     = {i_rem, i_src[2*RTW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_t >= w_trial);
        w_diff  = w_t - w_trial;
        n_rem   = w_ge ? w_diff[RTW+1:0] : w_t[RTW+1:0];
        n_root  = {i_root[RTW-2:0], w_ge};
        n_src   = {i_src[2*RTW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_src  <= n_src;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_src  = r_src;
    assign o_side = r_side;

endmodule

[rtl/core/ccs_div_cell.sv]
// One quotient bit of a multi-lane restoring divider with a shared divisor.
module ccs_div_cell import ccs_pkg::*; #(
    parameter int LANES = 2,
    parameter int RW    = 25,
    parameter int DW    = 24,
    parameter int QW    = 24,
    parameter int SW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_step_ctl                   i_ctl,
    input  logic [LANES-1:0][RW-1:0]    i_rem,
    input  logic [LANES-1:0][DW-1:0]    i_dvd,
    input  logic [LANES-1:0][QW-1:0]    i_quo,
    input  logic [RW-1:0]               i_den,
    input  logic [SW-1:0]               i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][RW-1:0]    o_rem,
    output logic [LANES-1:0][DW-1:0]    o_dvd,
    output logic [LANES-1:0][QW-1:0]    o_quo,
    output logic [RW-1:0]               o_den,
    output logic [SW-1:0]               o_side
);

    logic [LANES-1:0][RW:0]   w_t;
    logic [LANES-1:0][RW:0]   w_diff;
    logic [LANES-1:0]         w_ge;
    logic [LANES-1:0][RW-1:0] n_rem;
    logic [LANES-1:0][DW-1:0] n_dvd;
    logic [LANES-1:0][QW-1:0] n_quo;
    logic                     r_vld;
    logic [LANES-1:0][RW-1:0] r_rem;
    logic [LANES-1:0][DW-1:0] r_dvd;
    logic [LANES-1:0][QW-1:0] r_quo;
    logic [RW-1:0]            r_den;
    logic [SW-1:0]            r_side;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_t[l]    = {i_rem[l], i_dvd[l][DW-1]};
            w_ge[l]   = (w_t[l] >= {1'b0, i_den});
            w_diff[l] = w_t[l] - {1'b0, i_den};
            n_rem[l]  = w_ge[l] ? w_diff[l][RW-1:0] : w_t[l][RW-1:0];
            n_dvd[l]  = {i_dvd[l][DW-2:0], 1'b0};
            n_quo[l]  = {i_quo[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_rem  <= n_rem;
            r_dvd  <= n_dvd;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_dvd  = r_dvd;
    assign o_quo  = r_quo;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

[rtl/core/circle_collision_separation_top.sv]
// Top level of the circle collision separation pipeline.
//
// Input channel: i_valid / o_ready carry one circle pair (centers, radii,
// masses, fixed and ghost flags) per item. Output channel: o_valid / i_ready
// carry the outcome code, the push vector from B toward A and the shifts of
// both circles.
// The pipeline holds two front stages, one cell per root bit of the square
// root chain, two stages for overlap and product, one cell per quotient bit
// of the normal divider, one product stage, one cell per quotient bit of the
// mass divider, and the output register.
// Throughput is one item per cycle unless the output stalls; pairs are
// independent, so every cell takes a new item each cycle that it advances.
// The whole chain advances together; when the output register holds an
// item that is not taken, every cell holds and o_ready drops.
// Reset clears all valid bits; no item is in flight afterwards.
module circle_collision_separation_top import ccs_pkg::*; #(
    parameter int COORD_WIDTH = 24,
    parameter int MASS_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic [COORD_WIDTH-2:0]        i_a_radius,
    input  logic [MASS_WIDTH-1:0]         i_a_mass,
    input  logic                          i_a_fixed,
    input  logic                          i_a_ghost,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic [COORD_WIDTH-2:0]        i_b_radius,
    input  logic [MASS_WIDTH-1:0]         i_b_mass,
    input  logic                          i_b_fixed,
    input  logic                          i_b_ghost,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_outcome,
    output logic signed [COORD_WIDTH:0]   o_normal_x,
    output logic signed [COORD_WIDTH:0]   o_normal_y,
    output logic signed [COORD_WIDTH:0]   o_a_shift_x,
    output logic signed [COORD_WIDTH:0]   o_a_shift_y,
    output logic signed [COORD_WIDTH:0]   o_b_shift_x,
    output logic signed [COORD_WIDTH:0]   o_b_shift_y
);

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = MASS_WIDTH;
    localparam int RTW = CW + 1;
    localparam int NRW = CW + 1;
    localparam int MRW = MW + 2;

    typedef struct packed {
        logic          sgx;
        logic          sgy;
        logic [CW-1:0] mx;
        logic [CW-1:0] my;
        logic [CW-1:0] rsum;
        logic          af;
        logic          bf;
        logic          gh;
        logic [MW-1:0] am;
        logic [MW-1:0] bm;
        logic [MW+1:0] den;
    } t_geo;

    typedef struct packed {
        logic          sgx;
        logic          sgy;
        logic          collide;
        logic          dzero;
        logic          af;
        logic          bf;
        logic          gh;
        logic [MW-1:0] am;
        logic [MW-1:0] bm;
        logic [MW+1:0] den;
    } t_sel;

    typedef struct packed {
        logic              sgx;
        logic              sgy;
        logic [CW:0]       nx;
        logic [CW:0]       ny;
        logic              collide;
        logic              af;
        logic              bf;
        logic              gh;
    } t_fin;

    localparam int GEO_W = $bits(t_geo);
    localparam int SEL_W = $bits(t_sel);
    localparam int FIN_W = $bits(t_fin);

    logic w_adv;

    // front stage: differences, magnitudes, mass fixup
    logic [CW:0]   w_dx;
    logic [CW:0]   w_dy;
    logic [CW:0]   w_mdx;
    logic [CW:0]   w_mdy;
    logic [MW:0]   w_msum;
    t_geo          n_a;
    t_geo          r_a;
    logic          r_a_vld;

    always_comb begin
        w_dx   = {i_a_x[CW-1], i_a_x} - {i_b_x[CW-1], i_b_x};
        w_dy   = {i_a_y[CW-1], i_a_y} - {i_b_y[CW-1], i_b_y};
        w_mdx  = w_dx[CW] ? (~w_dx + 1'b1) : w_dx;
        w_mdy  = w_dy[CW] ? (~w_dy + 1'b1) : w_dy;
        w_msum = {1'b0, i_a_mass} + {1'b0, i_b_mass};
        n_a.sgx  = w_dx[CW];
        n_a.sgy  = w_dy[CW];
        n_a.mx   = w_mdx[CW-1:0];
        n_a.my   = w_mdy[CW-1:0];
        n_a.rsum = {1'b0, i_a_radius} + {1'b0, i_b_radius};
        n_a.af   = i_a_fixed;
        n_a.bf   = i_b_fixed;
        n_a.gh   = i_a_ghost | i_b_ghost;
        if (w_msum == '0) begin
            n_a.am  = MW'(1);
            n_a.bm  = MW'(1);
            n_a.den = (MW+2)'(4);
        end else begin
            n_a.am  = i_a_mass;
            n_a.bm  = i_b_mass;
            n_a.den = {w_msum, 1'b0};
        end
    end

    // square stage
    logic [2*CW-1:0] w_sqx;
    logic [2*CW-1:0] w_sqy;
    logic [2*CW:0]   n_b_s;
    logic [2*CW:0]   r_b_s;
    t_geo            r_b;
    logic            r_b_vld;

    always_comb begin
        w_sqx = r_a.mx * r_a.mx;
        w_sqy = r_a.my * r_a.my;
        n_b_s = {1'b0, w_sqx} + {1'b0, w_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a   <= n_a;
            r_b   <= r_a;
            r_b_s <= n_b_s;
        end
    end

    // square root chain
    logic             sq_vld  [0:RTW];
    logic [RTW+1:0]   sq_rem  [0:RTW];
    logic [RTW-1:0]   sq_root [0:RTW];
    logic [2*RTW-1:0] sq_src  [0:RTW];
    logic [GEO_W-1:0] sq_side [0:RTW];

    assign sq_vld[0]  = r_b_vld;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_src[0]  = {1'b0, r_b_s};
    assign sq_side[0] = r_b;

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        ccs_sqrt_cell #(
            .RTW (RTW),
            .SW  (GEO_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  ('{adv: w_adv, vld: sq_vld[k]}),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_src  (sq_src[k]),
            .i_side (sq_side[k]),
            .o_vld  (sq_vld[k+1]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_src  (sq_src[k+1]),
            .o_side (sq_side[k+1])
        );
    end

    // overlap stage
    t_geo          w_g;
    logic [CW:0]   w_d;
    logic          w_collide;
    logic          r_c_vld;
    t_sel          r_c;
    logic [CW-1:0] r_c_mx;
    logic [CW-1:0] r_c_my;
    logic [CW-1:0] r_c_ov;
    logic [CW:0]   r_c_d;
    t_sel          n_c;
    logic [CW-1:0] n_c_ov;

    always_comb begin
        w_g       = t_geo'(sq_side[RTW]);
        w_d       = sq_root[RTW];
        w_collide = (w_d <= {1'b0, w_g.rsum});
        n_c_ov    = w_collide ? (w_g.rsum - w_d[CW-1:0]) : '0;
        n_c.sgx     = w_g.sgx;
        n_c.sgy     = w_g.sgy;
        n_c.collide = w_collide;
        n_c.dzero   = (w_d == '0);
        n_c.af      = w_g.af;
        n_c.bf      = w_g.bf;
        n_c.gh      = w_g.gh;
        n_c.am      = w_g.am;
        n_c.bm      = w_g.bm;
        n_c.den     = w_g.den;
    end

    // product stage
    logic [2*CW-1:0] n_d_px;
    logic [2*CW-1:0] n_d_py;
    logic [2*CW-1:0] r_d_px;
    logic [2*CW-1:0] r_d_py;
    logic [CW:0]     r_d_d;
    t_sel            r_d;
    logic            r_d_vld;

    always_comb begin
        n_d_px = r_c_mx * r_c_ov;
        n_d_py = r_c_my * r_c_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= sq_vld[RTW];
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c    <= n_c;
            r_c_mx <= w_g.mx;
            r_c_my <= w_g.my;
            r_c_ov <= n_c_ov;
            r_c_d  <= w_d;
            r_d    <= r_c;
            r_d_px <= n_d_px;
            r_d_py <= n_d_py;
            r_d_d  <= r_c_d;
        end
    end

    // normal divider chain: lane 0 x, lane 1 y
    logic                 nd_vld  [0:CW];
    logic [1:0][NRW-1:0]  nd_rem  [0:CW];
    logic [1:0][CW-1:0]   nd_dvd  [0:CW];
    logic [1:0][CW-1:0]   nd_quo  [0:CW];
    logic [NRW-1:0]       nd_den  [0:CW];
    logic [SEL_W-1:0]     nd_side [0:CW];

    assign nd_vld[0]     = r_d_vld;
    assign nd_rem[0][0]  = {1'b0, r_d_px[2*CW-1:CW]};
    assign nd_rem[0][1]  = {1'b0, r_d_py[2*CW-1:CW]};
    assign nd_dvd[0][0]  = r_d_px[CW-1:0];
    assign nd_dvd[0][1]  = r_d_py[CW-1:0];
    assign nd_quo[0]     = '0;
    assign nd_den[0]     = r_d_d;
    assign nd_side[0]    = r_d;

    for (genvar k = 0; k < CW; k++) begin : g_ndiv
        ccs_div_cell #(
            .LANES(2),
            .RW   (NRW),
            .DW   (CW),
            .QW   (CW),
            .SW   (SEL_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  ('{adv: w_adv, vld: nd_vld[k]}),
            .i_rem  (nd_rem[k]),
            .i_dvd  (nd_dvd[k]),
            .i_quo  (nd_quo[k]),
            .i_den  (nd_den[k]),
            .i_side (nd_side[k]),
            .o_vld  (nd_vld[k+1]),
            .o_rem  (nd_rem[k+1]),
            .o_dvd  (nd_dvd[k+1]),
            .o_quo  (nd_quo[k+1]),
            .o_den  (nd_den[k+1]),
            .o_side (nd_side[k+1])
        );
    end

    // normal sign and mass product stage
    t_sel                   w_s;
    logic [CW-1:0]          w_nmx;
    logic [CW-1:0]          w_nmy;
    t_fin                   n_e;
    logic [3:0][CW+MW-1:0]  n_e_p;
    t_fin                   r_e;
    logic [3:0][CW+MW-1:0]  r_e_p;
    logic [MW+1:0]          r_e_den;
    logic                   r_e_vld;

    always_comb begin
        w_s   = t_sel'(nd_side[CW]);
        w_nmx = w_s.dzero ? '0 : nd_quo[CW][0];
        w_nmy = w_s.dzero ? '0 : nd_quo[CW][1];
        n_e.sgx     = w_s.sgx;
        n_e.sgy     = w_s.sgy;
        n_e.nx      = w_s.sgx ? (~{1'b0, w_nmx} + 1'b1) : {1'b0, w_nmx};
        n_e.ny      = w_s.sgy ? (~{1'b0, w_nmy} + 1'b1) : {1'b0, w_nmy};
        n_e.collide = w_s.collide;
        n_e.af      = w_s.af;
        n_e.bf      = w_s.bf;
        n_e.gh      = w_s.gh;
        n_e_p[0]    = w_nmx * w_s.bm;
        n_e_p[1]    = w_nmy * w_s.bm;
        n_e_p[2]    = w_nmx * w_s.am;
        n_e_p[3]    = w_nmy * w_s.am;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= nd_vld[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e     <= n_e;
            r_e_p   <= n_e_p;
            r_e_den <= w_s.den;
        end
    end

    // mass divider chain: lanes A x, A y, B x, B y
    logic                 md_vld  [0:CW];
    logic [3:0][MRW-1:0]  md_rem  [0:CW];
    logic [3:0][CW-1:0]   md_dvd  [0:CW];
    logic [3:0][CW-1:0]   md_quo  [0:CW];
    logic [MRW-1:0]       md_den  [0:CW];
    logic [FIN_W-1:0]     md_side [0:CW];

    assign md_vld[0]  = r_e_vld;
    assign md_quo[0]  = '0;
    assign md_den[0]  = r_e_den;
    assign md_side[0] = r_e;

    for (genvar l = 0; l < 4; l++) begin : g_mlane
        assign md_rem[0][l] = {2'b00, r_e_p[l][CW+MW-1:CW]};
        assign md_dvd[0][l] = r_e_p[l][CW-1:0];
    end

    for (genvar k = 0; k < CW; k++) begin : g_mdiv
        ccs_div_cell #(
            .LANES(4),
            .RW   (MRW),
            .DW   (CW),
            .QW   (CW),
            .SW   (FIN_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  ('{adv: w_adv, vld: md_vld[k]}),
            .i_rem  (md_rem[k]),
            .i_dvd  (md_dvd[k]),
            .i_quo  (md_quo[k]),
            .i_den  (md_den[k]),
            .i_side (md_side[k]),
            .o_vld  (md_vld[k+1]),
            .o_rem  (md_rem[k+1]),
            .o_dvd  (md_dvd[k+1]),
            .o_quo  (md_quo[k+1]),
            .o_den  (md_den[k+1]),
            .o_side (md_side[k+1])
        );
    end

    // output stage
    t_fin        w_f;
    logic [CW:0] w_qax;
    logic [CW:0] w_qay;
    logic [CW:0] w_qbx;
    logic [CW:0] w_qby;
    logic [1:0]  n_outcome;
    logic [CW:0] n_nx;
    logic [CW:0] n_ny;
    logic [CW:0] n_sax;
    logic [CW:0] n_say;
    logic [CW:0] n_sbx;
    logic [CW:0] n_sby;
    logic        r_o_vld;
    logic [1:0]  r_outcome;
    logic [CW:0] r_nx;
    logic [CW:0] r_ny;
    logic [CW:0] r_sax;
    logic [CW:0] r_say;
    logic [CW:0] r_sbx;
    logic [CW:0] r_sby;

    always_comb begin
        w_f   = t_fin'(md_side[CW]);
        w_qax = {1'b0, md_quo[CW][0]};
        w_qay = {1'b0, md_quo[CW][1]};
        w_qbx = {1'b0, md_quo[CW][2]};
        w_qby = {1'b0, md_quo[CW][3]};
        n_outcome = OUTCOME_APART;
        n_nx  = '0;
        n_ny  = '0;
        n_sax = '0;
        n_say = '0;
        n_sbx = '0;
        n_sby = '0;
        if (w_f.collide) begin
            n_nx = w_f.nx;
            n_ny = w_f.ny;
            if (w_f.gh) begin
                n_outcome = OUTCOME_GHOST;
            end else begin
                n_outcome = OUTCOME_RESOLVED;
                if (!w_f.af && w_f.bf) begin
                    n_sax = w_f.nx;
                    n_say = w_f.ny;
                end else if (w_f.af && !w_f.bf) begin
                    n_sbx = ~w_f.nx + 1'b1;
                    n_sby = ~w_f.ny + 1'b1;
                end else if (!w_f.af && !w_f.bf) begin
                    n_sax = w_f.sgx ? (~w_qax + 1'b1) : w_qax;
                    n_say = w_f.sgy ? (~w_qay + 1'b1) : w_qay;
                    n_sbx = w_f.sgx ? w_qbx : (~w_qbx + 1'b1);
                    n_sby = w_f.sgy ? w_qby : (~w_qby + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= md_vld[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_outcome <= n_outcome;
            r_nx      <= n_nx;
            r_ny      <= n_ny;
            r_sax     <= n_sax;
            r_say     <= n_say;
            r_sbx     <= n_sbx;
            r_sby     <= n_sby;
        end
    end

    assign w_adv       = !r_o_vld || i_ready;
    assign o_ready     = w_adv;
    assign o_valid     = r_o_vld;
    assign o_outcome   = r_outcome;
    assign o_normal_x  = r_nx;
    assign o_normal_y  = r_ny;
    assign o_a_shift_x = r_sax;
    assign o_a_shift_y = r_say;
    assign o_b_shift_x = r_sbx;
    assign o_b_shift_y = r_sby;

    a_apart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome == OUTCOME_APART |->
            o_normal_x == '0 && o_normal_y == '0)
        else $error("apart pair with nonzero normal");

    a_ghost_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome == OUTCOME_GHOST |->
            o_a_shift_x == '0 && o_a_shift_y == '0 &&
            o_b_shift_x == '0 && o_b_shift_y == '0)
        else $error("ghost pair with nonzero shift");

    a_shift_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_a_shift_x != '0 |-> o_a_shift_x[CW] == o_normal_x[CW])
        else $error("shift of A opposes the normal");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld && !w_adv |=> r_e_vld && $stable(r_e_p))
        else $error("mass product stage moved during stall");

endmodule
